FILE: sv/tss_pkg.sv
// Shared types and constants for the temperature scan statistics block.
// No dependencies; the design files and the bench import this package.
`timescale 1ns / 1ps

package tss_pkg;

  // Pack severity, ordered so that a larger code is worse
  typedef enum logic [1:0] {
    SEV_INIT    = 2'd0,
    SEV_NORMAL  = 2'd1,
    SEV_WARNING = 2'd2,
    SEV_DANGER  = 2'd3
  } sev_t;

  // Configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_WARNING = 1'b0;
  localparam cfg_index_t CFG_DANGER  = 1'b1;

  localparam int TEMP_W       = 8;
  localparam int MAT_SUM_W    = 16;
  localparam int PTC_SUM_W    = 12;

  localparam logic [TEMP_W-1:0] WARNING_RESET = 8'd50;
  localparam logic [TEMP_W-1:0] DANGER_RESET  = 8'd58;
  localparam logic [TEMP_W-1:0] LOWEST_RESET  = 8'd100;

  // One input request
  typedef struct packed {
    logic              kind;         // 0 matrix, 1 PTC
    logic [TEMP_W-1:0] temperature;
    logic              scan_start;
    logic              clear_stats;
  } tss_item_t;

  // Running statistics after one sample
  typedef struct packed {
    sev_t                 severity;
    logic [TEMP_W-1:0]    top_one;
    logic [TEMP_W-1:0]    top_two;
    logic [TEMP_W-1:0]    top_three;
    logic [TEMP_W-1:0]    lowest;
    logic [TEMP_W-1:0]    ptc_highest;
    logic [MAT_SUM_W-1:0] matrix_sum;
    logic [PTC_SUM_W-1:0] ptc_sum;
  } tss_stats_t;

  localparam tss_stats_t STATS_RESET = '{
    severity:    SEV_INIT,
    top_one:     '0,
    top_two:     '0,
    top_three:   '0,
    lowest:      LOWEST_RESET,
    ptc_highest: '0,
    matrix_sum:  '0,
    ptc_sum:     '0
  };

  // Finished result
  typedef struct packed {
    sev_t              pack_state;
    logic [TEMP_W-1:0] max_first;
    logic [TEMP_W-1:0] max_second;
    logic [TEMP_W-1:0] max_third;
    logic [TEMP_W-1:0] min_temp;
    logic [TEMP_W-1:0] ptc_max;
    logic [TEMP_W-1:0] matrix_average;
    logic [TEMP_W-1:0] ptc_average;
  } tss_result_t;

endpackage

FILE: sv/tss_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Standalone; field widths follow the block's fixed field widths.
`timescale 1ns / 1ps

interface tss_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] temperature;
  logic       scan_start;
  logic       clear_stats;

  modport source (output valid, kind, temperature, scan_start, clear_stats, input ready);
  modport sink   (input valid, kind, temperature, scan_start, clear_stats, output ready);
endinterface

interface tss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] pack_state;
  logic [7:0] max_first;
  logic [7:0] max_second;
  logic [7:0] max_third;
  logic [7:0] min_temp;
  logic [7:0] ptc_max;
  logic [7:0] matrix_average;
  logic [7:0] ptc_average;

  modport source (output valid, pack_state, max_first, max_second, max_third, min_temp,
                  ptc_max, matrix_average, ptc_average, input ready);
  modport sink   (input valid, pack_state, max_first, max_second, max_third, min_temp,
                  ptc_max, matrix_average, ptc_average, output ready);
endinterface

FILE: sv/temperature_scan_statistics.sv
// Temperature scan statistics: takes one converted cell temperature per cycle and returns
// one result per sample with the pack state, top three matrix maxima, matrix minimum, PTC
// maximum and the two scan averages. A sample is accepted in every cycle while the output
// side keeps up. Its result passes through the input register, the statistics update and
// the average stage, each of them registered. Each sample updates the statistics
// registers through a handful of 8-bit compares and a saturating add. Averages divide the
// running sums by MATRIX_CELLS and PTC_CELLS through a constant reciprocal multiply.
// Thresholds should be written only while the block holds no request.
`timescale 1ns / 1ps

module temperature_scan_statistics #(
  parameter int MATRIX_CELLS = 132,
  parameter int PTC_CELLS    = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  tss_in_if.sink              in_ch,
  tss_out_if.source           out_ch,
  input  logic                cfg_we,
  input  tss_pkg::cfg_index_t cfg_index,
  input  logic [7:0]          cfg_wdata
);
  import tss_pkg::*;

  // Reciprocals: q = (x * M) >> S is exact for every x below 2^N
  localparam int MAT_SHIFT = MAT_SUM_W + $clog2(MATRIX_CELLS);
  localparam int PTC_SHIFT = PTC_SUM_W + $clog2(PTC_CELLS);
  localparam logic [MAT_SUM_W:0] MAT_RECIP =
    (MAT_SUM_W + 1)'(((64'd1 << MAT_SHIFT) + 64'(MATRIX_CELLS) - 64'd1) / 64'(MATRIX_CELLS));
  localparam logic [PTC_SUM_W:0] PTC_RECIP =
    (PTC_SUM_W + 1)'(((64'd1 << PTC_SHIFT) + 64'(PTC_CELLS) - 64'd1) / 64'(PTC_CELLS));
  localparam int MAT_PROD_W = 2 * MAT_SUM_W + 1;
  localparam int PTC_PROD_W = 2 * PTC_SUM_W + 1;

  logic [7:0]  warn_thr_r;
  logic [7:0]  danger_thr_r;

  logic        a_valid_r, a_valid_nxt;
  logic        b_valid_r, b_valid_nxt;
  logic        c_valid_r, c_valid_nxt;
  tss_item_t   a_item_r;
  tss_stats_t  b_stats_r;
  tss_stats_t  stats_nxt;
  tss_result_t c_res_r, c_res_nxt;

  logic a_ready, b_ready, c_ready;
  logic in_fire, a_fire, b_fire;

  logic [MAT_PROD_W-1:0] mat_prod;
  logic [PTC_PROD_W-1:0] ptc_prod;
  logic [MAT_SUM_W-1:0]  mat_quo;
  logic [PTC_SUM_W-1:0]  ptc_quo;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_thr_r   <= WARNING_RESET;
      danger_thr_r <= DANGER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WARNING: warn_thr_r   <= cfg_wdata;
        CFG_DANGER:  danger_thr_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Per-stage flow control: a stage loads when empty or when it empties this cycle
  always_comb begin
    c_ready      = !c_valid_r || out_ch.ready;
    b_ready      = !b_valid_r || c_ready;
    a_ready      = !a_valid_r || b_ready;
    in_ch.ready  = a_ready;
    in_fire      = in_ch.valid && a_ready;
    a_fire       = a_valid_r && b_ready;
    b_fire       = b_valid_r && c_ready;

    a_valid_nxt = in_fire ? 1'b1 : (a_fire ? 1'b0 : a_valid_r);
    b_valid_nxt = a_fire  ? 1'b1 : (b_fire ? 1'b0 : b_valid_r);
    c_valid_nxt = b_fire  ? 1'b1 : ((c_valid_r && out_ch.ready) ? 1'b0 : c_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
    end
  end

  // Stage A: hold the accepted request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item_r.kind        <= in_ch.kind;
      a_item_r.temperature <= in_ch.temperature;
      a_item_r.scan_start  <= in_ch.scan_start;
      a_item_r.clear_stats <= in_ch.clear_stats;
    end
  end

  // Statistics update, committed as the request moves into stage B
  tss_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_en     (a_fire),
    .item       (a_item_r),
    .warn_thr   (warn_thr_r),
    .danger_thr (danger_thr_r),
    .stats_nxt  (stats_nxt)
  );

  // Stage B: snapshot of the statistics after this sample
  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_stats_r <= stats_nxt;
    end
  end

  // Averages by reciprocal multiply, saturated to a byte
  always_comb begin
    mat_prod = MAT_PROD_W'(b_stats_r.matrix_sum) * MAT_PROD_W'(MAT_RECIP);
    ptc_prod = PTC_PROD_W'(b_stats_r.ptc_sum) * PTC_PROD_W'(PTC_RECIP);
    mat_quo  = MAT_SUM_W'(mat_prod >> MAT_SHIFT);
    ptc_quo  = PTC_SUM_W'(ptc_prod >> PTC_SHIFT);

    c_res_nxt.pack_state     = b_stats_r.severity;
    c_res_nxt.max_first      = b_stats_r.top_one;
    c_res_nxt.max_second     = b_stats_r.top_two;
    c_res_nxt.max_third      = b_stats_r.top_three;
    c_res_nxt.min_temp       = b_stats_r.lowest;
    c_res_nxt.ptc_max        = b_stats_r.ptc_highest;
    c_res_nxt.matrix_average = (mat_quo > MAT_SUM_W'(255)) ? 8'hFF : mat_quo[7:0];
    c_res_nxt.ptc_average    = (ptc_quo > PTC_SUM_W'(255)) ? 8'hFF : ptc_quo[7:0];
  end

  // Stage C: result register
  always_ff @(posedge clk) begin
    if (b_fire) begin
      c_res_r <= c_res_nxt;
    end
  end

  // Drive the result channel
  always_comb begin
    out_ch.valid          = c_valid_r;
    out_ch.pack_state     = c_res_r.pack_state;
    out_ch.max_first      = c_res_r.max_first;
    out_ch.max_second     = c_res_r.max_second;
    out_ch.max_third      = c_res_r.max_third;
    out_ch.min_temp       = c_res_r.min_temp;
    out_ch.ptc_max        = c_res_r.ptc_max;
    out_ch.matrix_average = c_res_r.matrix_average;
    out_ch.ptc_average    = c_res_r.ptc_average;
  end

endmodule

FILE: sv/tss_stats.sv
// Running statistics registers and their combinational update for one sample.
// Depends on tss_pkg for the item and statistics types.
`timescale 1ns / 1ps

module tss_stats (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd_en,
  input  tss_pkg::tss_item_t item,
  input  logic [7:0]         warn_thr,
  input  logic [7:0]         danger_thr,
  output tss_pkg::tss_stats_t stats_nxt
);
  import tss_pkg::*;

  tss_stats_t        stats_r;
  tss_stats_t        base;
  sev_t              level;
  logic [TEMP_W-1:0] t;
  logic [MAT_SUM_W:0] mat_add;
  logic [PTC_SUM_W:0] ptc_add;
  logic [MAT_SUM_W-1:0] mat_base;
  logic [PTC_SUM_W-1:0] ptc_base;

  always_comb begin
    t    = item.temperature;
    // clear acts before the sample is taken
    base = item.clear_stats ? STATS_RESET : stats_r;

    // classify this sample
    if (t >= danger_thr) begin
      level = SEV_DANGER;
    end else if (t >= warn_thr) begin
      level = SEV_WARNING;
    end else begin
      level = SEV_NORMAL;
    end

    stats_nxt = base;
    // severity only rises until a clear
    if (level > base.severity) begin
      stats_nxt.severity = level;
    end

    mat_base = item.scan_start ? '0 : base.matrix_sum;
    ptc_base = item.scan_start ? '0 : base.ptc_sum;
    mat_add  = {1'b0, mat_base} + {{(MAT_SUM_W + 1 - TEMP_W){1'b0}}, t};
    ptc_add  = {1'b0, ptc_base} + {{(PTC_SUM_W + 1 - TEMP_W){1'b0}}, t};

    if (item.kind) begin
      // PTC sample: saturating sum and maximum
      stats_nxt.ptc_sum = ptc_add[PTC_SUM_W] ? '1 : ptc_add[PTC_SUM_W-1:0];
      if (t > base.ptc_highest) begin
        stats_nxt.ptc_highest = t;
      end
    end else begin
      // matrix sample: saturating sum, top three and minimum
      stats_nxt.matrix_sum = mat_add[MAT_SUM_W] ? '1 : mat_add[MAT_SUM_W-1:0];
      if (t > base.top_one) begin
        stats_nxt.top_three = base.top_two;
        stats_nxt.top_two   = base.top_one;
        stats_nxt.top_one   = t;
      end else if (t > base.top_two) begin
        stats_nxt.top_three = base.top_two;
        stats_nxt.top_two   = t;
      end else if (t > base.top_three) begin
        stats_nxt.top_three = t;
      end
      if (t < base.lowest) begin
        stats_nxt.lowest = t;
      end
    end
  end

  // Commit the update when the sample moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r <= STATS_RESET;
    end else if (upd_en) begin
      stats_r <= stats_nxt;
    end
  end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for temperature_scan_statistics: directed table, then random scans.
// Depends on tss_pkg, the tss_in_if/tss_out_if interfaces and the block itself.
// Every accepted request is folded into a local statistics copy; results are checked in order.
`timescale 1ns / 1ps

module testbench;
  import tss_pkg::*;

  localparam int MATRIX_CELLS = 132;
  localparam int PTC_CELLS    = 12;
  localparam int unsigned MAT_CAP = (1 << MAT_SUM_W) - 1;
  localparam int unsigned PTC_CAP = (1 << PTC_SUM_W) - 1;
  localparam logic KIND_MATRIX = 1'b0;
  localparam logic KIND_PTC    = 1'b1;
  localparam tss_result_t NO_REF = '0;

  // One row of the directed table: a request, how often to send it, and an optional
  // hand-computed result that replaces the predicted one
  typedef struct {
    tss_item_t   req;
    int unsigned reps;
    bit          typed;
    tss_result_t want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [7:0] cfg_wdata;

  tss_in_if  in_ch ();
  tss_out_if out_ch ();

  // Local copy of the thresholds and the running statistics
  logic [7:0]  thr_warn;
  logic [7:0]  thr_danger;
  tss_stats_t  tally;
  tss_result_t reports_due [$];
  int unsigned samples_sent;
  int unsigned mismatches;
  bit          no_gaps;

  probe_row_t probe_rows [22] = '{
    // clear with scan start on a cold sample
    '{'{KIND_MATRIX, 8'd0, 1'b1, 1'b1}, 1, 1'b1,
      '{SEV_NORMAL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    // hottest matrix sample
    '{'{KIND_MATRIX, 8'd255, 1'b0, 1'b0}, 1, 1'b1,
      '{SEV_DANGER, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0}},
    // hottest PTC sample right after a clear
    '{'{KIND_PTC, 8'd255, 1'b1, 1'b1}, 1, 1'b1,
      '{SEV_DANGER, 8'd0, 8'd0, 8'd0, 8'd100, 8'd255, 8'd0, 8'd21}},
    // just below warning, then exactly at warning
    '{'{KIND_MATRIX, 8'd49, 1'b1, 1'b1}, 1, 1'b1,
      '{SEV_NORMAL, 8'd49, 8'd0, 8'd0, 8'd49, 8'd0, 8'd0, 8'd0}},
    '{'{KIND_MATRIX, 8'd50, 1'b0, 1'b0}, 1, 1'b1,
      '{SEV_WARNING, 8'd50, 8'd49, 8'd0, 8'd49, 8'd0, 8'd0, 8'd0}},
    // just below danger, equal maxima, danger and its duplicates
    '{'{KIND_MATRIX, 8'd57, 1'b0, 1'b0}, 1, 1'b0, NO_REF},
    '{'{KIND_MATRIX, 8'd50, 1'b0, 1'b0}, 1, 1'b0, NO_REF},
    '{'{KIND_MATRIX, 8'd58, 1'b0, 1'b0}, 1, 1'b0, NO_REF},
    '{'{KIND_MATRIX, 8'd58, 1'b0, 1'b0}, 1, 1'b0, NO_REF},
    '{'{KIND_MATRIX, 8'd58, 1'b0, 1'b0}, 1, 1'b0, NO_REF},
    '{'{KIND_MATRIX, 8'd1, 1'b0, 1'b0}, 1, 1'b0, NO_REF},
    // PTC scans
    '{'{KIND_PTC, 8'd0, 1'b1, 1'b0}, 1, 1'b0, NO_REF},
    '{'{KIND_PTC, 8'd128, 1'b0, 1'b0}, 1, 1'b0, NO_REF},
    '{'{KIND_PTC, 8'd3, 1'b1, 1'b0}, 1, 1'b0, NO_REF},
    // both flags on a sample equal to the minimum reset value
    '{'{KIND_MATRIX, 8'd100, 1'b1, 1'b1}, 1, 1'b1,
      '{SEV_DANGER, 8'd100, 8'd0, 8'd0, 8'd100, 8'd0, 8'd0, 8'd0}},
    // overlong scans: saturate both sums and both averages
    '{'{KIND_MATRIX, 8'd255, 1'b0, 1'b0}, 300, 1'b0, NO_REF},
    '{'{KIND_PTC, 8'd255, 1'b0, 1'b0}, 20, 1'b0, NO_REF},
    // restart scans after saturation
    '{'{KIND_MATRIX, 8'd7, 1'b1, 1'b0}, 1, 1'b0, NO_REF},
    '{'{KIND_PTC, 8'd9, 1'b1, 1'b0}, 1, 1'b0, NO_REF},
    // clear without scan start
    '{'{KIND_MATRIX, 8'd0, 1'b0, 1'b1}, 1, 1'b0, NO_REF},
    '{'{KIND_PTC, 8'd200, 1'b0, 1'b1}, 1, 1'b0, NO_REF},
    '{'{KIND_MATRIX, 8'd255, 1'b1, 1'b0}, 1, 1'b0, NO_REF}
  };

  temperature_scan_statistics #(
    .MATRIX_CELLS (MATRIX_CELLS),
    .PTC_CELLS    (PTC_CELLS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Fold one sample into the running statistics and return the report it yields
  task automatic fold_sample(input tss_item_t req, output tss_result_t r);
    sev_t lvl;
    int unsigned sum;
    int unsigned avg;
    begin
      if (req.clear_stats) tally = STATS_RESET;
      if (req.temperature >= thr_danger) lvl = SEV_DANGER;
      else if (req.temperature >= thr_warn) lvl = SEV_WARNING;
      else lvl = SEV_NORMAL;
      if (lvl > tally.severity) tally.severity = lvl;
      if (req.kind == KIND_PTC) begin
        if (req.scan_start) tally.ptc_sum = '0;
        sum = tally.ptc_sum + req.temperature;
        if (sum > PTC_CAP) sum = PTC_CAP;
        tally.ptc_sum = sum[PTC_SUM_W-1:0];
        if (req.temperature > tally.ptc_highest) tally.ptc_highest = req.temperature;
      end else begin
        if (req.scan_start) tally.matrix_sum = '0;
        sum = tally.matrix_sum + req.temperature;
        if (sum > MAT_CAP) sum = MAT_CAP;
        tally.matrix_sum = sum[MAT_SUM_W-1:0];
        if (req.temperature > tally.top_one) begin
          tally.top_three = tally.top_two;
          tally.top_two   = tally.top_one;
          tally.top_one   = req.temperature;
        end else if (req.temperature > tally.top_two) begin
          tally.top_three = tally.top_two;
          tally.top_two   = req.temperature;
        end else if (req.temperature > tally.top_three) begin
          tally.top_three = req.temperature;
        end
        if (req.temperature < tally.lowest) tally.lowest = req.temperature;
      end
      r.pack_state = tally.severity;
      r.max_first  = tally.top_one;
      r.max_second = tally.top_two;
      r.max_third  = tally.top_three;
      r.min_temp   = tally.lowest;
      r.ptc_max    = tally.ptc_highest;
      avg = tally.matrix_sum / MATRIX_CELLS;
      r.matrix_average = (avg > 255) ? 8'd255 : avg[7:0];
      avg = tally.ptc_sum / PTC_CELLS;
      r.ptc_average = (avg > 255) ? 8'd255 : avg[7:0];
    end
  endtask

  // Offer one request from a falling edge; return at the falling edge after acceptance
  task automatic push_sample(input tss_item_t req, input bit typed, input tss_result_t want);
    tss_result_t predicted;
    begin
      while (!no_gaps && $urandom_range(0, 99) < 18) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.kind        <= req.kind;
      in_ch.temperature <= req.temperature;
      in_ch.scan_start  <= req.scan_start;
      in_ch.clear_stats <= req.clear_stats;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      fold_sample(req, predicted);
      reports_due.push_back(typed ? want : predicted);
      samples_sent++;
      @(negedge clk);
    end
  endtask

  // Drop valid, wait until every report is back, then let the pipeline settle
  task automatic drain();
    begin
      in_ch.valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clk);
      repeat (8) @(negedge clk);
    end
  endtask

  // Write the warning threshold, then the danger threshold; called from a falling edge while idle
  task automatic set_thresholds(input logic [7:0] warn, input logic [7:0] danger);
    begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_WARNING;
      cfg_wdata <= warn;
      @(negedge clk);
      cfg_index <= CFG_DANGER;
      cfg_wdata <= danger;
      @(negedge clk);
      cfg_we <= 1'b0;
      thr_warn   = warn;
      thr_danger = danger;
    end
  endtask

  // Temperatures biased toward the extremes and both thresholds
  function automatic logic [7:0] pick_temp();
    int v;
    begin
      case ($urandom_range(0, 9))
        0: v = $urandom_range(0, 1) ? 255 : 0;
        1, 2: v = int'(thr_warn) + int'($urandom_range(0, 2)) - 1;
        3: v = int'(thr_danger) + int'($urandom_range(0, 2)) - 1;
        default: v = $urandom_range(0, 255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      pick_temp = v[7:0];
    end
  endfunction

  // Random scans: mostly well-formed matrix and PTC scans, some overlong hot scans and noise
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    tss_item_t   req;
    begin
      stop_at = samples_sent + count;
      while (samples_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 24);
          for (int unsigned k = 0; k < len; k++) begin
            req.kind        = KIND_MATRIX;
            req.temperature = pick_temp();
            req.scan_start  = (k == 0);
            req.clear_stats = (k == 0) && ($urandom_range(0, 9) == 0);
            push_sample(req, 1'b0, NO_REF);
          end
        end else if (pick < 82) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 16);
          for (int unsigned k = 0; k < len; k++) begin
            req.kind        = KIND_PTC;
            req.temperature = pick_temp();
            req.scan_start  = (k == 0);
            req.clear_stats = (k == 0) && ($urandom_range(0, 9) == 0);
            push_sample(req, 1'b0, NO_REF);
          end
        end else if (pick < 85) begin
          len = $urandom_range(130, 300);
          for (int unsigned k = 0; k < len; k++) begin
            req.kind        = KIND_MATRIX;
            req.temperature = 8'($urandom_range(200, 255));
            req.scan_start  = (k == 0);
            req.clear_stats = 1'b0;
            push_sample(req, 1'b0, NO_REF);
          end
        end else begin
          len = $urandom_range(1, 4);
          for (int unsigned k = 0; k < len; k++) begin
            req.kind        = 1'($urandom_range(0, 1));
            req.temperature = 8'($urandom_range(0, 255));
            req.scan_start  = 1'($urandom_range(0, 1));
            req.clear_stats = ($urandom_range(0, 3) == 0);
            push_sample(req, 1'b0, NO_REF);
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    begin
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    end
  endtask

  // Compare each accepted report with the oldest outstanding one
  always @(posedge clk) begin
    tss_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (reports_due.size() == 0) begin
        $display("%0t: report with no request outstanding, got state %0d max %0d",
                 $time, out_ch.pack_state, out_ch.max_first);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        check_field("pack_state", 8'(want.pack_state), 8'(out_ch.pack_state));
        check_field("max_first", want.max_first, out_ch.max_first);
        check_field("max_second", want.max_second, out_ch.max_second);
        check_field("max_third", want.max_third, out_ch.max_third);
        check_field("min_temp", want.min_temp, out_ch.min_temp);
        check_field("ptc_max", want.ptc_max, out_ch.ptc_max);
        check_field("matrix_average", want.matrix_average, out_ch.matrix_average);
        check_field("ptc_average", want.ptc_average, out_ch.ptc_average);
      end
    end
  end

  // Stall the result side at random unless a steady stretch is running
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 18);
    end
  end

  // Main sequence: reset, directed table, then random phases under several thresholds
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_WARNING;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_MATRIX;
    in_ch.temperature = '0;
    in_ch.scan_start  = 1'b0;
    in_ch.clear_stats = 1'b0;
    no_gaps           = 1'b0;
    samples_sent      = 0;
    mismatches        = 0;
    thr_warn          = WARNING_RESET;
    thr_danger        = DANGER_RESET;
    tally             = STATS_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under the reset thresholds
    foreach (probe_rows[i])
      repeat (probe_rows[i].reps)
        push_sample(probe_rows[i].req, probe_rows[i].typed, probe_rows[i].want);
    drain();

    set_thresholds(8'd30, 8'd90);
    run_random(120);
    drain();
    set_thresholds(8'd0, 8'd0);
    run_random(100);
    drain();
    set_thresholds(8'd255, 8'd255);
    run_random(100);
    drain();
    // warning above danger: danger wins wherever it applies
    set_thresholds(8'd200, 8'd20);
    run_random(100);
    drain();
    // steady stretch: no gaps on either side
    set_thresholds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    no_gaps = 1'b1;
    run_random(100);
    drain();
    no_gaps = 1'b0;
    set_thresholds(WARNING_RESET, DANGER_RESET);
    run_random(140);
    drain();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
sv/tss_pkg.sv
sv/tss_if.sv
sv/tss_stats.sv
sv/temperature_scan_statistics.sv
bench/testbench.sv
